// ===== rtl/irt_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// irt_pkg: shared types and constants of the interval reservation table
// sizes of the table and the time words, result codes, cell link type
// ----------------------------------------------------------------------------
package irt_pkg;

	localparam int TABLE_DEPTH = 64;
	localparam int TIME_W      = 32;
	localparam int FIELD_W     = 32;
	localparam int USED_W      = 7;
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

	typedef logic [TIME_W-1:0] time_t;
	typedef logic [CNT_W-1:0]  cnt_t;

	typedef enum logic [1:0] {
		ST_BOOKED  = 2'd0,
		ST_OVERLAP = 2'd1,
		ST_FULL    = 2'd2
	} status_t;

	// token and running overlap flag passed from cell to cell
	typedef struct packed {
		logic tok;
		logic hit;
	} irt_link_t;

endpackage : irt_pkg
`default_nettype wire

// ===== rtl/irt_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// irt_cell: one entry of the reservation table
// holds one interval, checks the broadcast request against it when the scan
// token passes, and forwards token and overlap flag to the next cell
// ----------------------------------------------------------------------------
module irt_cell (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire irt_pkg::time_t      req_start,
	input  wire irt_pkg::time_t      req_end,
	input  wire irt_pkg::irt_link_t  link_in,
	output irt_pkg::irt_link_t       link_out,
	input  wire                      wr_en
);
	import irt_pkg::*;

	logic      valid_q;
	time_t     start_q;
	time_t     end_q;
	irt_link_t link_q;
	logic      overlap;

	// half-open intervals overlap unless one ends at or before the other starts
	assign overlap = valid_q && (req_start < end_q) && (start_q < req_end);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			link_q  <= '0;
		end else begin
			link_q.tok <= link_in.tok;
			link_q.hit <= link_in.tok && (link_in.hit || overlap);
			if (wr_en) begin
				valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			start_q <= req_start;
			end_q   <= req_end;
		end
	end

	assign link_out = link_q;

endmodule : irt_cell
`default_nettype wire

// ===== rtl/interval_reservation_table_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// interval_reservation_table_unit: half-open interval booking table
// checks each requested interval against all stored ones and appends it
// when it overlaps none and a free entry is left
// ----------------------------------------------------------------------------
// usage
//  - request channel: start_time/end_time are taken at a rising edge with
//    start high and busy low; busy stays high until the result is out
//  - result channel: done is high for exactly one cycle with accepted,
//    status (booked, overlap, full) and used_entries; the receiver cannot
//    stall, so the beat must be taken in that cycle
//  - a scan token walks the row of TABLE_DEPTH cells, one cell per cycle,
//    picking up an overlap flag; the result is launched when it leaves the
//    last cell; busy drops in the same cycle as done, so a new request is
//    taken at the edge ending it, and never before the last one is through
//  - a booked interval is written into the first free cell at the edge that
//    launches the result, so the next scan already sees it
//  - overlap wins over a full table
//  - reset (arst_n low) empties the table: all valid bits and the entry
//    count clear at once, no sweep is needed
// ----------------------------------------------------------------------------
module interval_reservation_table_unit (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        start,
	output logic                       busy,
	input  wire [irt_pkg::FIELD_W-1:0] start_time,
	input  wire [irt_pkg::FIELD_W-1:0] end_time,
	output logic                       done,
	output logic                       accepted,
	output logic [1:0]                 status,
	output logic [irt_pkg::USED_W-1:0] used_entries
);
	import irt_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_SCAN = 2'b10
	} state_t;

	state_t    state_q;
	logic      take;
	logic      inject_q;
	time_t     req_start_q;
	time_t     req_end_q;
	cnt_t      count_q;
	logic      done_q;
	logic      accepted_q;
	status_t   status_q;
	logic      scan_end;
	logic      table_full;
	logic      book;

	// link[i] feeds cell i, link[TABLE_DEPTH] leaves the last cell
	irt_link_t link [TABLE_DEPTH+1];

	assign busy = (state_q == S_SCAN);
	assign take = start && !busy;

	// the token leaves the row once every cell has been checked
	assign scan_end   = link[TABLE_DEPTH].tok;
	assign table_full = (count_q == CNT_W'(TABLE_DEPTH));
	assign book       = scan_end && !link[TABLE_DEPTH].hit && !table_full;

	// the token is registered in inject_q at the edge that latches the request, then enters the first cell
	assign link[0].tok = inject_q;
	assign link[0].hit = 1'b0;

	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		irt_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.req_start (req_start_q),
			.req_end   (req_end_q),
			.link_in   (link[i]),
			.link_out  (link[i+1]),
			.wr_en     (book && (count_q == CNT_W'(i)))
		);
	end

	// request capture, input fields are cast to the time width
	always_ff @(posedge clk) begin
		if (take) begin
			req_start_q <= TIME_W'(start_time);
			req_end_q   <= TIME_W'(end_time);
		end
	end

	// sequencer: idle until a request, then wait for the token to come out
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			inject_q <= 1'b0;
		end else begin
			inject_q <= take;
			unique case (state_q)
				S_IDLE: begin
					if (take) begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (scan_end) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// entry count and result beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= scan_end;
			if (book) begin
				count_q <= count_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (scan_end) begin
			accepted_q <= book;
			if (link[TABLE_DEPTH].hit) begin
				status_q <= ST_OVERLAP;
			end else if (table_full) begin
				status_q <= ST_FULL;
			end else begin
				status_q <= ST_BOOKED;
			end
		end
	end

	assign done         = done_q;
	assign accepted     = accepted_q;
	assign status       = status_q;
	// count already reflects the write made with this result
	assign used_entries = USED_W'(count_q);

endmodule : interval_reservation_table_unit
`default_nettype wire
